### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define UMPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition must never be seen at a rising clock edge outside reset
`define UMPQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define UMPQ_ASSERT(lbl, clk, rstn, prop, msg)
`define UMPQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### rtl/core/umpq_pkg.sv
// ----------------------------------------------------------------------------
// umpq_pkg
// shared constants and control types of the unsorted max-priority queue
// ----------------------------------------------------------------------------
package umpq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ECNT_W   = 7;
  localparam int unsigned ENTRY_W  = 2 * DATA_W;

  // input beat layout
  localparam int unsigned IN_TDATA_W  = 72;
  // output beat layout
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (ENTRY_W + STATUS_W + ECNT_W + 1);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_EXTRACT  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MODIFY   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DECREASE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_INCREASE = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_SMALLER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_GREATER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted item and arm the scan
    logic scan;    // advance the store scan by one entry
    logic commit;  // write back, update count, load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;  // incoming item has to search the store
    logic scan_done;  // scan reached its last entry or a match
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

### rtl/core/unsorted_max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue_top
// max-priority queue of value/priority pairs held in an unsorted store
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents (lowest bits first)
//  s_axis   | in  | func[2:0], item_value[31:0], item_priority[31:0], 5'b0
//  m_axis   | out | out_value[31:0], out_priority[31:0], status[2:0],
//           |     | entry_count[6:0], is_empty, 5'b0
//
//  insert and unused codes: no scan, the item goes from idle straight to finish
//  extract, peek and key ops: the filled entries are scanned one by one, key ops
//  stopping at the first match, through the single read port of the store
//  one item is in work at a time; a finished result sits in the output
//  register while the next input beat is taken
//  reset clears the fill count and control state; the store needs no clearing
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue_top #(
  parameter int unsigned CAPACITY = umpq_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // func, item_value, item_priority
  input  logic [umpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_value, out_priority, status, entry_count, is_empty
  output logic [umpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // command and status between sequencer and datapath
  umpq_pkg::cmd_t cmd;
  umpq_pkg::sts_t sts;

  // sequencer: idle -> (scan) -> finish, finish waits for a free result slot
  umpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: entry ram, running max / first-match search, write-back
  umpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

### rtl/core/umpq_ram.sv
// ----------------------------------------------------------------------------
// umpq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module umpq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/umpq_ctrl.sv
// ----------------------------------------------------------------------------
// umpq_ctrl
// operation sequencer: accept, scan, commit
// ----------------------------------------------------------------------------
module umpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  umpq_pkg::sts_t sts_i,
  output umpq_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    s_tready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.need_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/umpq_dp.sv
// ----------------------------------------------------------------------------
// umpq_dp
// entry store, scan compare unit, write-back and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module umpq_dp #(
  parameter int unsigned CAPACITY = umpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  umpq_pkg::cmd_t                     cmd_i,
  output umpq_pkg::sts_t                     sts_o,
  input  logic [umpq_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic                               m_tready_i,
  output logic                               m_tvalid_o,
  output logic [umpq_pkg::OUT_TDATA_W-1:0]   m_tdata_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DW    = umpq_pkg::DATA_W;
  localparam int unsigned FW    = umpq_pkg::FUNC_W;
  localparam int unsigned EW    = umpq_pkg::ECNT_W;

  // input fields
  logic [FW-1:0] in_func;
  logic [DW-1:0] in_val;
  logic [DW-1:0] in_pri;

  assign in_func = in_data_i[FW-1:0];
  assign in_val  = in_data_i[FW+DW-1:FW];
  assign in_pri  = in_data_i[FW+2*DW-1:FW+DW];

  // latched item
  logic [FW-1:0] func_q;
  logic [DW-1:0] val_q, pri_q;

  // store and scan state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [DW-1:0]    best_val_q, best_pri_q;
  logic [2*DW-1:0]  last_q;

  logic [2*DW-1:0]  rd_data;
  logic [DW-1:0]    rd_val, rd_pri;

  logic             is_key, is_max;
  logic             last_now, match_now, take_max;
  logic             rd_more;

  // write-back and result
  logic             wb_en, ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [2*DW-1:0]  ram_wdata;
  logic [umpq_pkg::STATUS_W-1:0] res_st;
  logic [DW-1:0]    res_val, res_pri;
  logic [CNT_W+EW-1:0] cnt_ext;
  logic             out_vld_q;
  logic [umpq_pkg::OUT_TDATA_W-1:0] out_data_q;

  umpq_ram #(
    .WIDTH (2 * DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_val = rd_data[DW-1:0];
  assign rd_pri = rd_data[2*DW-1:DW];

  assign is_key = func_q inside {umpq_pkg::FN_MODIFY, umpq_pkg::FN_DECREASE,
                                 umpq_pkg::FN_INCREASE};
  assign is_max = func_q inside {umpq_pkg::FN_EXTRACT, umpq_pkg::FN_PEEK};

  assign last_now  = cmp_vld_q && (CNT_W'(cmp_idx_q) == cnt_q - CNT_W'(1));
  assign match_now = cmp_vld_q && is_key && (rd_val == val_q);
  assign take_max  = cmp_vld_q && is_max &&
                     ((cmp_idx_q == '0) || ($signed(rd_pri) > $signed(best_pri_q)));
  assign rd_more   = rd_idx_q < cnt_q;

  assign sts_o.need_scan = (in_func inside {[umpq_pkg::FN_EXTRACT:umpq_pkg::FN_INCREASE]})
                           && (cnt_q != '0);
  assign sts_o.scan_done = last_now || match_now;
  assign sts_o.out_free  = !out_vld_q || m_tready_i;

  // item latch and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func;
      val_q  <= in_val;
      pri_q  <= in_pri;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
      if (cmp_vld_q) begin
        last_q <= rd_data;
      end
      if (take_max || (match_now && !found_q)) begin
        best_idx_q <= cmp_idx_q;
        best_val_q <= rd_val;
        best_pri_q <= rd_pri;
      end
    end
    if (cmd_i.commit) begin
      out_data_q <= {{umpq_pkg::OUT_PAD_W{1'b0}}, (cnt_d == '0), cnt_ext[EW-1:0],
                     res_st, res_pri, res_val};
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (cmd_i.load) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_q <= rd_more;
      if (rd_more) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (match_now) begin
        found_q <= 1'b1;
      end
    end
  end

  // operation outcome
  always_comb begin
    wb_en     = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = {pri_q, val_q};
    cnt_d     = cnt_q;
    res_st    = umpq_pkg::ST_OK;
    res_val   = '0;
    res_pri   = '0;
    case (func_q)
      umpq_pkg::FN_INSERT: begin
        if (cnt_q == CNT_W'(CAPACITY)) begin
          res_st = umpq_pkg::ST_FULL;
        end else begin
          wb_en     = 1'b1;
          ram_waddr = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      umpq_pkg::FN_EXTRACT, umpq_pkg::FN_PEEK: begin
        if (cnt_q == '0) begin
          res_st = umpq_pkg::ST_EMPTY;
        end else begin
          res_val = best_val_q;
          res_pri = best_pri_q;
          if (func_q == umpq_pkg::FN_EXTRACT) begin
            // last entry fills the freed slot
            wb_en     = 1'b1;
            ram_wdata = last_q;
            cnt_d     = cnt_q - CNT_W'(1);
          end
        end
      end
      umpq_pkg::FN_MODIFY, umpq_pkg::FN_DECREASE, umpq_pkg::FN_INCREASE: begin
        if (!found_q) begin
          res_st = umpq_pkg::ST_NOT_FOUND;
        end else if ((func_q == umpq_pkg::FN_DECREASE) &&
                     !($signed(best_pri_q) > $signed(pri_q))) begin
          res_st = umpq_pkg::ST_NOT_SMALLER;
        end else if ((func_q == umpq_pkg::FN_INCREASE) &&
                     !($signed(pri_q) > $signed(best_pri_q))) begin
          res_st = umpq_pkg::ST_NOT_GREATER;
        end else begin
          wb_en = 1'b1;
        end
      end
      default: begin
        wb_en = 1'b0;
      end
    endcase
  end

  assign ram_we  = wb_en && cmd_i.commit;
  assign cnt_ext = {{EW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

  `UMPQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(CAPACITY), "fill count above capacity")
  `UMPQ_ASSERT(a_cnt_commit, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> $past(cmd_i.commit), "count moved without commit")
  `UMPQ_ASSERT(a_wr_range, clk_i, rst_ni, ram_we |-> (CNT_W'(ram_waddr) <= cnt_q), "store write beyond fill")
  `UMPQ_ASSERT_NEVER(a_cmp_range, clk_i, rst_ni, cmd_i.scan && cmp_vld_q && (CNT_W'(cmp_idx_q) >= cnt_q), "compare beyond fill")

endmodule
